/* rtl/core/pws_pkg.sv */
`timescale 1ns / 1ps

package pws_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int FRAC_BITS   = 14;
    localparam int NUM_COEFS   = 7;
    localparam int CNT_W       = 3;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TAPS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE   = 4'd1;

    localparam logic [CNT_W-1:0] WINDOW_TAPS_RESET = 3'd7;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;

    localparam coef_t COEF_RESET [NUM_COEFS] = '{
        -16'sd1560, 16'sd2341, 16'sd4681, 16'sd5461, 16'sd4681, 16'sd2341, -16'sd1560
    };

    typedef struct packed {
        sample_t sample;
        logic    last;
    } in_item_t;

    typedef struct packed {
        sample_t value;
        logic    end_of_stream;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [CNT_W-1:0] seen;
        logic [CNT_W-1:0] taps;
    } stage_ctl_t;

endpackage

/* rtl/core/polynomial_window_smoother.sv */
`timescale 1ns / 1ps

// Savitzky-Golay style smoother over an odd window of 1 to MAX_TAPS samples (one less
// for an even MAX_TAPS) with signed Q2.14 weights; each result is centred on the sample
// half a window back and the stream edges pass through raw. A sample transaction is taken
// every cycle unless the output side holds the flow; the seven products and their sum fit
// between the window register and the result register, and results leave the latter one
// per cycle while m_ready is high. A sample marked last yields up to half a window plus
// one results, so the input stalls while they drain. Configuration writes are taken at
// any time but must only be issued while the block is idle; the port is always ready.
module polynomial_window_smoother #(
    parameter int MAX_TAPS = 7
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  pws_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output pws_pkg::out_item_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pws_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pws_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pws_pkg::*;

    logic [CNT_W-1:0] window_taps_reg;
    coef_t            coef_reg [NUM_COEFS];
    stage_ctl_t       stage_ctl;
    sample_t          stage_win [MAX_TAPS];
    sample_t          smooth;
    logic             advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_taps_reg <= WINDOW_TAPS_RESET;
            coef_reg        <= COEF_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_WINDOW_TAPS) begin
                window_taps_reg <= cfg_data[CNT_W-1:0];
            end
            for (int i = 0; i < NUM_COEFS; i++) begin
                if (cfg_index == REG_COEF_BASE + CFG_IDX_W'(i)) begin
                    coef_reg[i] <= cfg_data[COEF_BITS-1:0];
                end
            end
        end
    end

    pws_window #(
        .MAX_TAPS (MAX_TAPS)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .window_taps (window_taps_reg),
        .advance     (advance),
        .stage_ctl   (stage_ctl),
        .stage_win   (stage_win)
    );

    pws_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .win    (stage_win),
        .coef   (coef_reg),
        .taps   (stage_ctl.taps),
        .smooth (smooth)
    );

    pws_batch #(
        .MAX_TAPS (MAX_TAPS)
    ) u_batch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stage_ctl (stage_ctl),
        .stage_win (stage_win),
        .smooth    (smooth),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* rtl/core/pws_window.sv */
`timescale 1ns / 1ps

module pws_window #(
    parameter int MAX_TAPS = 7
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  pws_pkg::in_item_t          s_data,
    input  logic [pws_pkg::CNT_W-1:0]  window_taps,
    input  logic                       advance,
    output pws_pkg::stage_ctl_t        stage_ctl,
    output pws_pkg::sample_t           stage_win [MAX_TAPS]
);
    import pws_pkg::*;

    localparam logic [CNT_W-1:0] WIN_CAP  = CNT_W'((MAX_TAPS - 1) | 1);
    localparam logic [CNT_W-1:0] SEEN_MAX = '1;

    sample_t          delay_reg [MAX_TAPS];
    sample_t          shifted   [MAX_TAPS];
    sample_t          win_reg   [MAX_TAPS];
    logic [CNT_W-1:0] seen_reg;
    logic [CNT_W-1:0] seen_next;
    logic [CNT_W-1:0] taps_eff;
    stage_ctl_t       ctl_reg;
    logic             accept;

    assign s_ready = !ctl_reg.valid || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        shifted[0] = s_data.sample;
        for (int k = 1; k < MAX_TAPS; k++) begin
            shifted[k] = delay_reg[k-1];
        end
        seen_next = (seen_reg == SEEN_MAX) ? SEEN_MAX : seen_reg + 1'b1;
        taps_eff  = window_taps | CNT_W'(1);
        if (taps_eff > WIN_CAP) begin
            taps_eff = WIN_CAP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= '0;
            ctl_reg.valid <= 1'b0;
            for (int k = 0; k < MAX_TAPS; k++) begin
                delay_reg[k] <= '0;
            end
        end else if (accept) begin
            ctl_reg.valid <= 1'b1;
            ctl_reg.last  <= s_data.last;
            ctl_reg.seen  <= seen_next;
            ctl_reg.taps  <= taps_eff;
            if (s_data.last) begin
                seen_reg <= '0;
                for (int k = 0; k < MAX_TAPS; k++) begin
                    delay_reg[k] <= '0;
                end
            end else begin
                seen_reg <= seen_next;
                for (int k = 0; k < MAX_TAPS; k++) begin
                    delay_reg[k] <= shifted[k];
                end
            end
        end else if (advance) begin
            ctl_reg.valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < MAX_TAPS; k++) begin
                win_reg[k] <= shifted[k];
            end
        end
    end

    assign stage_ctl = ctl_reg;
    assign stage_win = win_reg;

endmodule

/* rtl/core/pws_mac.sv */
`timescale 1ns / 1ps

module pws_mac #(
    parameter int MAX_TAPS = 7
) (
    input  pws_pkg::sample_t          win  [MAX_TAPS],
    input  pws_pkg::coef_t            coef [pws_pkg::NUM_COEFS],
    input  logic [pws_pkg::CNT_W-1:0] taps,
    output pws_pkg::sample_t          smooth
);
    import pws_pkg::*;

    localparam int TAP_IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W     = PROD_W + $clog2(MAX_TAPS + 1);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  quo;
    logic signed [PROD_W-1:0] prod;
    logic [CNT_W-1:0]         idx;
    logic                     all_ones;
    logic                     all_zeros;

    always_comb begin
        acc = '0;
        for (int j = 0; j < MAX_TAPS; j++) begin
            idx  = (CNT_W'(j) < taps) ? taps - CNT_W'(j) - 1'b1 : '0;
            prod = win[idx[TAP_IDX_W-1:0]] * coef[j];
            if (CNT_W'(j) < taps) begin
                acc = acc + ACC_W'(prod);
            end
        end
        rnd       = acc + ROUND_HALF;
        quo       = rnd >>> FRAC_BITS;
        all_ones  = &quo[ACC_W-1:SAMPLE_BITS-1];
        all_zeros = ~|quo[ACC_W-1:SAMPLE_BITS-1];
        if (all_ones || all_zeros) begin
            smooth = quo[SAMPLE_BITS-1:0];
        end else if (quo[ACC_W-1]) begin
            smooth = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            smooth = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule

/* rtl/core/pws_batch.sv */
`timescale 1ns / 1ps

module pws_batch #(
    parameter int MAX_TAPS = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pws_pkg::stage_ctl_t   stage_ctl,
    input  pws_pkg::sample_t      stage_win [MAX_TAPS],
    input  pws_pkg::sample_t      smooth,
    output logic                  advance,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pws_pkg::out_item_t    m_data
);
    import pws_pkg::*;

    localparam int TAP_IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int WIN_CAP   = (MAX_TAPS - 1) | 1;
    localparam int BATCH     = (WIN_CAP - 1) / 2 + 1;
    localparam int RD_W      = (BATCH > 1) ? $clog2(BATCH) : 1;

    out_item_t        entry_reg [BATCH];
    out_item_t        entry_next [BATCH];
    logic [CNT_W-1:0] rem_reg;
    logic [RD_W-1:0]  rd_reg;
    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] idx;
    logic             pop;

    assign m_valid = (rem_reg != '0);
    assign m_data  = entry_reg[rd_reg];
    assign pop     = m_valid && m_ready;
    assign advance = stage_ctl.valid && ((rem_reg == '0) || (rem_reg == CNT_W'(1) && m_ready));

    always_comb begin
        half = stage_ctl.taps >> 1;
        if (stage_ctl.last) begin
            count = (stage_ctl.seen < half + 1'b1) ? stage_ctl.seen : half + 1'b1;
        end else begin
            count = (stage_ctl.seen >= half + 1'b1) ? CNT_W'(1) : '0;
        end
        for (int e = 0; e < BATCH; e++) begin
            if (stage_ctl.last) begin
                idx = (CNT_W'(e) < count) ? count - CNT_W'(e) - 1'b1 : '0;
            end else begin
                idx = half;
            end
            if (idx == half && stage_ctl.seen >= stage_ctl.taps) begin
                entry_next[e].value = smooth;
            end else begin
                entry_next[e].value = stage_win[idx[TAP_IDX_W-1:0]];
            end
            entry_next[e].end_of_stream = stage_ctl.last && (idx == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            rd_reg  <= '0;
        end else if (advance) begin
            rem_reg <= count;
            rd_reg  <= '0;
        end else if (pop) begin
            rem_reg <= rem_reg - 1'b1;
            rd_reg  <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            entry_reg <= entry_next;
        end
    end

endmodule

/* dv/polynomial_window_smoother_tb.sv */
`timescale 1ns / 1ps

module polynomial_window_smoother_tb;
    import pws_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam coef_t   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam coef_t   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam int      SEEN_LIMIT = (1 << CNT_W) - 1;
    localparam int      ITEMS_PER_PHASE = 20;
    localparam int      DRAIN_CYCLES = 12;
    localparam int      RX_HOLD_CYCLES = 80;
    localparam int      MAX_PRINTED = 40;

    class window_scoreboard;
        sample_t          history [NUM_COEFS];
        int               seen;
        logic [CNT_W-1:0] taps;
        coef_t            coefs [NUM_COEFS];
        out_item_t        expected_outputs [$];
        int               mismatches;

        function new();
            taps = WINDOW_TAPS_RESET;
            for (int j = 0; j < NUM_COEFS; j++) begin
                coefs[j] = COEF_RESET[j];
                history[j] = '0;
            end
            seen = 0;
            mismatches = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_WINDOW_TAPS) begin
                taps = data[CNT_W-1:0];
            end else if (int'(idx) >= int'(REG_COEF_BASE)
                         && int'(idx) < int'(REG_COEF_BASE) + NUM_COEFS) begin
                coefs[int'(idx) - int'(REG_COEF_BASE)] = coef_t'(data);
            end
        endfunction

        function sample_t window_sum(int w);
            longint acc;
            longint r;
            longint hi;
            longint lo;
            hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
            lo = -hi - 1;
            acc = 0;
            for (int j = 0; j < w; j++) begin
                acc += longint'(history[w - 1 - j]) * longint'(coefs[j]);
            end
            r = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (r > hi) r = hi;
            if (r < lo) r = lo;
            return sample_t'(r);
        endfunction

        function void take_sample(in_item_t item);
            int        w;
            int        h;
            int        n;
            int        m;
            int        idx;
            out_item_t e;
            w = int'(taps | CNT_W'(1));
            h = (w - 1) / 2;
            for (int k = NUM_COEFS - 1; k > 0; k--) begin
                history[k] = history[k - 1];
            end
            history[0] = item.sample;
            n = (seen + 1 > SEEN_LIMIT) ? SEEN_LIMIT : seen + 1;
            if (!item.last) begin
                seen = n;
                if (n >= h + 1) begin
                    e.value = (n >= w) ? window_sum(w) : history[h];
                    e.end_of_stream = 1'b0;
                    expected_outputs.push_back(e);
                end
            end else begin
                m = (n < h + 1) ? n : h + 1;
                for (int k = m; k > 0; k--) begin
                    idx = k - 1;
                    e.value = (idx == h && n >= w) ? window_sum(w) : history[idx];
                    e.end_of_stream = (idx == 0);
                    expected_outputs.push_back(e);
                end
                foreach (history[k]) history[k] = '0;
                seen = 0;
            end
        endfunction

        task report(string what);
            if (mismatches < MAX_PRINTED) $display("%0t mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_output(out_item_t got);
            out_item_t want;
            if (expected_outputs.size() == 0) begin
                report($sformatf("unexpected output value %0d end_of_stream %0b",
                                 got.value, got.end_of_stream));
                return;
            end
            want = expected_outputs.pop_front();
            if (got.value !== want.value) begin
                report($sformatf("value %0d, expected %0d", got.value, want.value));
            end
            if (got.end_of_stream !== want.end_of_stream) begin
                report($sformatf("end_of_stream %0b, expected %0b",
                                 got.end_of_stream, want.end_of_stream));
            end
        endtask

        function int pending();
            return expected_outputs.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit reset_done;
    bit no_gaps;
    bit hold_req;
    int sent_items;

    window_scoreboard sb = new();

    polynomial_window_smoother u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_output(m_data);
        end
    end

    initial begin
        int r;
        m_ready = 1'b0;
        wait (reset_done);
        forever begin
            @(negedge aclk);
            r = $urandom_range(0, 99);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!no_gaps && r < 30) begin
                m_ready <= 1'b0;
                if (r < 26) repeat ($urandom_range(1, 3)) @(negedge aclk);
                else repeat ($urandom_range(10, 40)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return SAMPLE_MAX;
        if (r < 20) return SAMPLE_MIN;
        if (r < 50) return sample_t'(int'($urandom_range(0, 4000)) - 2000);
        return sample_t'($urandom);
    endfunction

    task automatic send_sample(input sample_t smp, input logic lst);
        in_item_t item;
        int       gap;
        item.sample = smp;
        item.last = lst;
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_sample(item);
        sent_items++;
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_register(idx, data);
        @(negedge aclk);
    endtask

    task automatic program_registers(input logic [CFG_DATA_W-1:0] taps_word,
                                     input coef_t c [NUM_COEFS]);
        write_register(REG_WINDOW_TAPS, taps_word);
        for (int j = 0; j < NUM_COEFS; j++) begin
            write_register(CFG_IDX_W'(int'(REG_COEF_BASE) + j), CFG_DATA_W'(c[j]));
        end
        cfg_valid <= 1'b0;
    endtask

    // Leaves the block idle: every expected output is in and the pipeline has drained.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        coef_t                 c [NUM_COEFS];
        logic [CFG_DATA_W-1:0] taps_word;
        int                    taps_order [8];
        int                    mode;
        int                    len;
        int                    phase_start;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        reset_done = 1'b0;
        no_gaps = 1'b0;
        hold_req = 1'b0;
        sent_items = 0;
        taps_order = '{0, 7, 1, 5, 2, 4, 3, 6};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        reset_done = 1'b1;

        // Reset weights, window of seven: a one-sample stream, then a full stream.
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b1);
        settle();

        // Extreme weights drive the sum into saturation on both sides.
        c = '{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN};
        program_registers(CFG_DATA_W'(3), c);
        for (int i = 0; i < 4; i++) send_sample(SAMPLE_MAX, i == 3);
        for (int i = 0; i < 4; i++) send_sample(SAMPLE_MIN, i == 3);
        settle();

        // The window shrinks to one sample in the middle of a stream; an unmapped
        // register index is written and must change nothing.
        send_sample(16'sd5, 1'b0);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd9, 1'b0);
        settle();
        write_register(REG_WINDOW_TAPS, 16'hFFF8);
        write_register(REG_UNMAPPED, 16'h1234);
        cfg_valid <= 1'b0;
        send_sample(16'sd11, 1'b0);
        send_sample(-16'sd13, 1'b1);
        settle();

        for (int p = 0; p < 8; p++) begin
            mode = p % 3;
            for (int j = 0; j < NUM_COEFS; j++) begin
                if (mode == 0) c[j] = coef_t'(int'($urandom_range(0, 12000)) - 6000);
                else if (mode == 1) c[j] = coef_t'($urandom);
                else c[j] = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            end
            taps_word = CFG_DATA_W'($urandom);
            taps_word[CNT_W-1:0] = CNT_W'(taps_order[p]);
            program_registers(taps_word, c);
            no_gaps = (p == 2 || p == 5);
            if (p == 2) hold_req = 1'b1;
            phase_start = sent_items;
            while (sent_items - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 15) len = $urandom_range(1, 3);
                else len = $urandom_range(4, 14);
                for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
            end
            settle();
        end

        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/pws_pkg.sv
rtl/core/pws_window.sv
rtl/core/pws_mac.sv
rtl/core/pws_batch.sv
rtl/core/polynomial_window_smoother.sv
dv/polynomial_window_smoother_tb.sv
